// ===== rtl/core/kvag_pkg.sv =====
`default_nettype none

package kvag_pkg;

   localparam int FLAT_W   = 45;
   localparam int DIV_W    = 9;
   localparam int DIV_STEP = 4;
   localparam int BUF_W    = 21;
   localparam int OFF_W    = 36;
   localparam int CSR_W    = 9;

   localparam int MODE_HND       = 0;
   localparam int MODE_FROM_UNIV = 1;

   typedef enum logic [3:0] {
      CSR_NUM_HEADS    = 4'd0,
      CSR_NUM_LAYERS   = 4'd1,
      CSR_NUM_OUTER    = 4'd2,
      CSR_TOKENS       = 4'd3,
      CSR_HEAD_DIM     = 4'd4,
      CSR_LAYERS_FULL  = 4'd5,
      CSR_LAYER_OFFSET = 4'd6,
      CSR_MODE         = 4'd7
   } csr_index_type;

   // indices peeled off so far, carried along the divider chain
   typedef struct packed {
      logic [8:0] dim;
      logic [8:0] tok;
      logic [2:0] outer;
      logic [7:0] layer;
   } idx_type;

endpackage

`default_nettype wire

// ===== rtl/core/kvag_div.sv =====
`default_nettype none

module kvag_div #(
   parameter int W    = 45,
   parameter int DW   = 9,
   parameter int STEP = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [W-1:0]         in_num,
   input  wire kvag_pkg::idx_type    in_pl,
   input  wire logic [DW-1:0]        divisor,
   output logic                      out_valid,
   output logic [W-1:0]              out_quot,
   output logic [DW-1:0]             out_rem,
   output kvag_pkg::idx_type         out_pl
);

   localparam int NS = (W + STEP - 1) / STEP;
   localparam int NB = NS * STEP;

   logic              valid_ff [NS];
   logic [NB-1:0]     num_ff   [NS];
   logic [DW-1:0]     rem_ff   [NS];
   kvag_pkg::idx_type pl_ff    [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      logic              src_valid;
      logic [NB-1:0]     src_num;
      logic [DW-1:0]     src_rem;
      kvag_pkg::idx_type src_pl;
      logic [NB-1:0]     num_in;
      logic [DW-1:0]     rem_in;

      if (g == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_num   = NB'(in_num);
         assign src_rem   = '0;
         assign src_pl    = in_pl;
      end else begin : g_next
         assign src_valid = valid_ff[g-1];
         assign src_num   = num_ff[g-1];
         assign src_rem   = rem_ff[g-1];
         assign src_pl    = pl_ff[g-1];
      end

      // restoring division, quotient bits shift in where dividend bits leave
      always_comb begin
         logic [DW:0]   r2;
         logic [NB-1:0] n;
         logic [DW-1:0] r;
         r = src_rem;
         n = src_num;
         for (int k = 0; k < STEP; k++) begin
            r2 = {r, n[NB-1]};
            n  = {n[NB-2:0], 1'b0};
            if (r2 >= {1'b0, divisor}) begin
               r2   = r2 - {1'b0, divisor};
               n[0] = 1'b1;
            end
            r = r2[DW-1:0];
         end
         num_in = n;
         rem_in = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= src_valid;
         end
         num_ff[g] <= num_in;
         rem_ff[g] <= rem_in;
         pl_ff[g]  <= src_pl;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quot  = num_ff[NS-1][W-1:0];
   assign out_rem   = rem_ff[NS-1];
   assign out_pl    = pl_ff[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/kv_block_universal_address_gen.sv =====
`default_nettype none

// element address generator for a copy between a block-stack chunk and a
// universal tensor
// input: a flat element index is taken at a rising edge with start high and
// busy low; busy is high only while reset is held and in the cycle after it
// results: rsp_valid marks each result for one cycle; the receiver cannot
// stall, every result is taken as it appears
// configuration: csr_we writes csr_wdata to register csr_index at the edge;
// indexes past the mode register are ignored; write only while idle
// throughput: one item per cycle sustained
// the index is split by five chained radix-16 dividers (dim, token, outer,
// layer, head), twelve stages each, then three stages of multiply and add
// an item with a zero dimension or an index past the last block gives no
// result
// reset clears the configuration to its defaults and empties the pipeline
module kv_block_universal_address_gen #(
   parameter int MAX_BLOCKS   = 4096,
   parameter int MAX_HEADS    = 256,
   parameter int MAX_LAYERS   = 128,
   parameter int MAX_TOKENS   = 256,
   parameter int MAX_HEAD_DIM = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [44:0] req_flat_index,
   output logic             rsp_valid,
   output logic [20:0]      rsp_read_buffer,
   output logic [35:0]      rsp_read_byte_offset,
   output logic [20:0]      rsp_write_buffer,
   output logic [35:0]      rsp_write_byte_offset,
   output logic [3:0]       rsp_element_bytes,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [12:0] HEADS_LIM  = 13'(MAX_HEADS);
   localparam logic [12:0] LAYERS_LIM = 13'(MAX_LAYERS);
   localparam logic [12:0] TOKENS_LIM = 13'(MAX_TOKENS);
   localparam logic [12:0] DIM_LIM    = 13'(MAX_HEAD_DIM);
   localparam logic [44:0] BLK_LIM    = 45'(MAX_BLOCKS);

   // configuration registers
   logic [8:0] num_heads_ff, num_layers_ff_w, tpb_ff, head_dim_ff;
   logic [7:0] num_layers_ff, layers_full_ff;
   logic [2:0] num_outer_ff;
   logic [6:0] layer_offset_ff;
   logic [3:0] mode_ff;
   logic       busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_heads_ff    <= 9'd8;
         num_layers_ff   <= 8'd1;
         num_outer_ff    <= 3'd2;
         tpb_ff          <= 9'd16;
         head_dim_ff     <= 9'd128;
         layers_full_ff  <= 8'd1;
         layer_offset_ff <= 7'd0;
         mode_ff         <= 4'd4;
         busy_ff         <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               kvag_pkg::CSR_NUM_HEADS:
                  num_heads_ff <= ({4'b0, csr_wdata} > HEADS_LIM) ?
                                  HEADS_LIM[8:0] : csr_wdata;
               kvag_pkg::CSR_NUM_LAYERS:
                  num_layers_ff <= ({5'b0, csr_wdata[7:0]} > LAYERS_LIM) ?
                                   LAYERS_LIM[7:0] : csr_wdata[7:0];
               kvag_pkg::CSR_NUM_OUTER:    num_outer_ff <= csr_wdata[2:0];
               kvag_pkg::CSR_TOKENS:
                  tpb_ff <= ({4'b0, csr_wdata} > TOKENS_LIM) ?
                            TOKENS_LIM[8:0] : csr_wdata;
               kvag_pkg::CSR_HEAD_DIM:
                  head_dim_ff <= ({4'b0, csr_wdata} > DIM_LIM) ?
                                 DIM_LIM[8:0] : csr_wdata;
               kvag_pkg::CSR_LAYERS_FULL:
                  layers_full_ff <= ({5'b0, csr_wdata[7:0]} > LAYERS_LIM) ?
                                    LAYERS_LIM[7:0] : csr_wdata[7:0];
               kvag_pkg::CSR_LAYER_OFFSET: layer_offset_ff <= csr_wdata[6:0];
               kvag_pkg::CSR_MODE:         mode_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;
   assign num_layers_ff_w = {1'b0, num_layers_ff};

   // strides, rebuilt every cycle; settled long before an item needs them
   logic [17:0] td_ff;
   logic [20:0] otd_ff;
   logic [28:0] fotd_ff;
   logic [10:0] lo_ff;

   always_ff @(posedge clock) begin
      td_ff   <= 18'(tpb_ff) * 18'(head_dim_ff);
      otd_ff  <= 21'(num_outer_ff) * 21'(td_ff);
      fotd_ff <= 29'(layers_full_ff) * 29'(otd_ff);
      lo_ff   <= 11'(num_layers_ff) * 11'(num_outer_ff);
   end

   logic dims_ok;
   assign dims_ok = (num_heads_ff != '0) && (num_layers_ff != '0) &&
                    (num_outer_ff != '0) && (tpb_ff != '0) && (head_dim_ff != '0);

   // divider chain
   logic              d0_v, d1_v, d2_v, d3_v, d4_v;
   logic [44:0]       d0_q, d1_q, d2_q, d3_q, d4_q;
   logic [8:0]        d0_r, d1_r, d2_r, d3_r, d4_r;
   kvag_pkg::idx_type d0_p, d1_p, d2_p, d3_p, d4_p;
   kvag_pkg::idx_type p1, p2, p3, p4;

   always_comb begin
      p1 = d0_p;
      p1.dim = d0_r;
      p2 = d1_p;
      p2.tok = d1_r;
      p3 = d2_p;
      p3.outer = d2_r[2:0];
      p4 = d3_p;
      p4.layer = d3_r[7:0];
   end

   kvag_div #(.W(kvag_pkg::FLAT_W), .DW(kvag_pkg::DIV_W), .STEP(kvag_pkg::DIV_STEP))
   u_div_dim (
      .clock(clock), .reset(reset),
      .in_valid(start && !busy_ff && dims_ok), .in_num(req_flat_index),
      .in_pl('0), .divisor(head_dim_ff),
      .out_valid(d0_v), .out_quot(d0_q), .out_rem(d0_r), .out_pl(d0_p)
   );

   kvag_div #(.W(kvag_pkg::FLAT_W), .DW(kvag_pkg::DIV_W), .STEP(kvag_pkg::DIV_STEP))
   u_div_tok (
      .clock(clock), .reset(reset),
      .in_valid(d0_v), .in_num(d0_q), .in_pl(p1), .divisor(tpb_ff),
      .out_valid(d1_v), .out_quot(d1_q), .out_rem(d1_r), .out_pl(d1_p)
   );

   kvag_div #(.W(kvag_pkg::FLAT_W), .DW(kvag_pkg::DIV_W), .STEP(kvag_pkg::DIV_STEP))
   u_div_outer (
      .clock(clock), .reset(reset),
      .in_valid(d1_v), .in_num(d1_q), .in_pl(p2), .divisor({6'b0, num_outer_ff}),
      .out_valid(d2_v), .out_quot(d2_q), .out_rem(d2_r), .out_pl(d2_p)
   );

   kvag_div #(.W(kvag_pkg::FLAT_W), .DW(kvag_pkg::DIV_W), .STEP(kvag_pkg::DIV_STEP))
   u_div_layer (
      .clock(clock), .reset(reset),
      .in_valid(d2_v), .in_num(d2_q), .in_pl(p3), .divisor(num_layers_ff_w),
      .out_valid(d3_v), .out_quot(d3_q), .out_rem(d3_r), .out_pl(d3_p)
   );

   kvag_div #(.W(kvag_pkg::FLAT_W), .DW(kvag_pkg::DIV_W), .STEP(kvag_pkg::DIV_STEP))
   u_div_head (
      .clock(clock), .reset(reset),
      .in_valid(d3_v), .in_num(d3_q), .in_pl(p4), .divisor(num_heads_ff),
      .out_valid(d4_v), .out_quot(d4_q), .out_rem(d4_r), .out_pl(d4_p)
   );

   logic hnd, from_univ;
   assign hnd       = mode_ff[kvag_pkg::MODE_HND];
   assign from_univ = mode_ff[kvag_pkg::MODE_FROM_UNIV];

   // stage 1: products
   logic             s1_valid_ff;
   logic [17:0]      m1_ff;
   logic [36:0]      u1_ff;
   logic [29:0]      u2_ff;
   logic [20:0]      u3_ff;
   logic [17:0]      u4_ff;
   logic [20:0]      sa_ff;
   logic [10:0]      sb_ff;
   logic [8:0]       dim1_ff;
   logic [BLK_W-1:0] blk1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= d4_v && (d4_q < BLK_LIM);
      end
      m1_ff   <= hnd ? 18'(d4_r) * 18'(tpb_ff) + 18'(d4_p.tok)
                     : 18'(d4_p.tok) * 18'(num_heads_ff) + 18'(d4_r);
      u1_ff   <= 37'(d4_r) * 37'(fotd_ff);
      u2_ff   <= 30'(10'(layer_offset_ff) + 10'(d4_p.layer)) * 30'(otd_ff);
      u3_ff   <= 21'(d4_p.outer) * 21'(td_ff);
      u4_ff   <= 18'(d4_p.tok) * 18'(head_dim_ff) + 18'(d4_p.dim);
      sa_ff   <= 21'(d4_q[BLK_W-1:0]) * 21'(lo_ff);
      sb_ff   <= 11'(d4_p.layer) * 11'(num_outer_ff) + 11'(d4_p.outer);
      dim1_ff <= d4_p.dim;
      blk1_ff <= d4_q[BLK_W-1:0];
   end

   // stage 2: chunk offset and partial sums
   logic             s2_valid_ff;
   logic [26:0]      chunk_ff;
   logic [37:0]      ua_ff;
   logic [21:0]      ub_ff;
   logic [20:0]      slot_ff;
   logic [BLK_W-1:0] blk2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      chunk_ff <= 27'(m1_ff) * 27'(head_dim_ff) + 27'(dim1_ff);
      ua_ff    <= 38'(u1_ff) + 38'(u2_ff);
      ub_ff    <= 22'(u3_ff) + 22'(u4_ff);
      slot_ff  <= sa_ff + 21'(sb_ff);
      blk2_ff  <= blk1_ff;
   end

   // stage 3: scale to bytes and pick direction
   logic [37:0] univ_sum;
   logic [40:0] univ_bytes, chunk_bytes;
   logic [20:0] blk_buf;

   assign univ_sum    = ua_ff + 38'(ub_ff);
   assign univ_bytes  = 41'(univ_sum) << mode_ff[3:2];
   assign chunk_bytes = 41'(chunk_ff) << mode_ff[3:2];
   assign blk_buf     = 21'(blk2_ff);

   logic        rsp_valid_ff;
   logic [20:0] rd_buf_ff, wr_buf_ff;
   logic [35:0] rd_off_ff, wr_off_ff;
   logic [3:0]  esz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
      if (from_univ) begin
         rd_buf_ff <= blk_buf;
         rd_off_ff <= univ_bytes[35:0];
         wr_buf_ff <= slot_ff;
         wr_off_ff <= chunk_bytes[35:0];
      end else begin
         rd_buf_ff <= slot_ff;
         rd_off_ff <= chunk_bytes[35:0];
         wr_buf_ff <= blk_buf;
         wr_off_ff <= univ_bytes[35:0];
      end
      esz_ff <= 4'd1 << mode_ff[3:2];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_buffer       = rd_buf_ff;
   assign rsp_read_byte_offset  = rd_off_ff;
   assign rsp_write_buffer      = wr_buf_ff;
   assign rsp_write_byte_offset = wr_off_ff;
   assign rsp_element_bytes     = esz_ff;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_esz_pow2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_element_bytes == 4'd1 || rsp_element_bytes == 4'd2 ||
                     rsp_element_bytes == 4'd4 || rsp_element_bytes == 4'd8))
      else $error("element size not a power of two");

   a_blk_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_read_buffer) < MAX_BLOCKS ||
                     32'(rsp_write_buffer) < MAX_BLOCKS))
      else $error("universal block index past the last block");

endmodule

`default_nettype wire
